/* rtl/core/dhcp_lop_pkg.sv */
// dhcp lease option parser package: option codes, cookie bytes, store and result types
`timescale 1ns / 1ps

package dhcp_lop_pkg;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PORTSET_CODE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LPR_CODE     = 1'b1;

  // configuration reset values
  localparam logic [7:0] PORTSET_CODE_RST = 8'd224;
  localparam logic [7:0] LPR_CODE_RST     = 8'd9;

  // fixed option codes
  localparam logic [7:0] OPT_PAD    = 8'd0;
  localparam logic [7:0] OPT_MASK   = 8'd1;
  localparam logic [7:0] OPT_ROUTER = 8'd3;
  localparam logic [7:0] OPT_DNS    = 8'd6;
  localparam logic [7:0] OPT_LEASE  = 8'd51;
  localparam logic [7:0] OPT_SERVER = 8'd54;
  localparam logic [7:0] OPT_RENEW  = 8'd58;
  localparam logic [7:0] OPT_END    = 8'hff;

  // magic cookie, one byte per position
  function automatic logic [7:0] cookie_byte(input logic [1:0] pos);
    logic [7:0] b;
    unique case (pos)
      2'd0: b = 8'h63;
      2'd1: b = 8'h82;
      2'd2: b = 8'h53;
      2'd3: b = 8'h63;
      default: b = 8'h63;
    endcase
    return b;
  endfunction

  // captured lease values of one packet
  typedef struct packed {
    logic [31:0] client;
    logic [31:0] server;
    logic [31:0] mask;
    logic [31:0] router;
    logic [31:0] dns;
    logic [31:0] ctrl;
    logic [31:0] lease;
    logic [31:0] renew;
    logic [15:0] port_index;
    logic [15:0] port_mask;
  } store_t;

  // one result transaction
  typedef struct packed {
    store_t lease;
    logic   cookie_valid;
  } result_t;

endpackage

/* rtl/core/dhcp_lease_option_parser.sv */
// DHCP lease option parser: cookie check, option walk and lease result output
`timescale 1ns / 1ps

// Takes the options area of a DHCP reply one byte per transaction, cookie
// first, and gives one result transaction after the byte flagged last_byte.
// A byte is taken while in_stall is low; the parse state is updated by short
// logic in the cycle it is accepted, and the result is registered as the last
// byte is accepted, into the output register or, while that is held, into a
// skid register behind it, so in_stall rises only while two results are
// waiting; a byte stream with at most one unread result never stalls. A byte
// with first_byte restarts parsing at once; bytes seen while no packet is open
// are dropped. Registers 0 and 1 set the port-set and LPR option codes and may
// be written only while no packet is being parsed or delivered.

module dhcp_lease_option_parser (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_option_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  input  logic [31:0] in_offered_address,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_client_address,
  output logic [31:0] out_server_address,
  output logic [31:0] out_subnet_mask,
  output logic [31:0] out_router_address,
  output logic [31:0] out_dns_address,
  output logic [31:0] out_controller_address,
  output logic [31:0] out_lease_seconds,
  output logic [31:0] out_renew_seconds,
  output logic [15:0] out_port_index,
  output logic [15:0] out_port_mask,
  output logic        out_cookie_valid,
  // configuration port
  input  logic                                cfg_write_en,
  input  logic [dhcp_lop_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                          cfg_wdata
);

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_COOKIE = 6'b000010,
    PH_CODE   = 6'b000100,
    PH_LEN    = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_END    = 6'b100000
  } phase_t;

  // configuration registers
  logic [7:0] portset_code_r;
  logic [7:0] lpr_code_r;

  // parse state
  phase_t               phase_r, phase_nxt;
  logic [1:0]           cpos_r, cpos_nxt;
  logic                 good_r, good_nxt;
  logic [7:0]           code_r, code_nxt;
  logic [7:0]           left_r, left_nxt;
  logic [2:0]           dpos_r, dpos_nxt;
  logic [31:0]          vshift_r, vshift_nxt;
  dhcp_lop_pkg::store_t store_r, store_nxt;

  // output register and skid
  logic                  out_valid_r;
  dhcp_lop_pkg::result_t out_data_r;
  logic                  skid_valid_r;
  dhcp_lop_pkg::result_t skid_data_r;

  logic                  in_acc;
  logic                  out_pop;
  logic                  commit;
  logic [31:0]           commit_val;
  logic                  produce;
  dhcp_lop_pkg::result_t result;

  assign in_stall = skid_valid_r;
  assign in_acc   = in_valid && !skid_valid_r;
  assign out_pop  = out_valid_r && !out_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      portset_code_r <= dhcp_lop_pkg::PORTSET_CODE_RST;
      lpr_code_r     <= dhcp_lop_pkg::LPR_CODE_RST;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        dhcp_lop_pkg::CFG_PORTSET_CODE: portset_code_r <= cfg_wdata;
        dhcp_lop_pkg::CFG_LPR_CODE:     lpr_code_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // byte step: restart, phase update, option commit and result build
  always_comb begin
    phase_nxt  = phase_r;
    cpos_nxt   = cpos_r;
    good_nxt   = good_r;
    code_nxt   = code_r;
    left_nxt   = left_r;
    dpos_nxt   = dpos_r;
    vshift_nxt = vshift_r;
    store_nxt  = store_r;
    commit     = 1'b0;
    commit_val = 32'd0;
    produce    = 1'b0;
    result     = '0;

    // new packet clears everything
    if (in_first_byte) begin
      phase_nxt        = PH_COOKIE;
      cpos_nxt         = 2'd0;
      good_nxt         = 1'b1;
      code_nxt         = 8'd0;
      left_nxt         = 8'd0;
      dpos_nxt         = 3'd0;
      vshift_nxt       = 32'd0;
      store_nxt        = '0;
      store_nxt.client = in_offered_address;
    end

    // phase step
    unique case (phase_nxt)
      PH_COOKIE: begin
        if (in_option_byte != dhcp_lop_pkg::cookie_byte(cpos_nxt)) good_nxt = 1'b0;
        if (cpos_nxt == 2'd3) begin
          cpos_nxt  = 2'd0;
          phase_nxt = PH_CODE;
        end else begin
          cpos_nxt = cpos_nxt + 2'd1;
        end
      end
      PH_CODE: begin
        if (in_option_byte == dhcp_lop_pkg::OPT_END) begin
          phase_nxt = PH_END;
        end else if (in_option_byte != dhcp_lop_pkg::OPT_PAD) begin
          code_nxt  = in_option_byte;
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        left_nxt   = in_option_byte;
        dpos_nxt   = 3'd0;
        vshift_nxt = 32'd0;
        if (in_option_byte == 8'd0) begin
          commit    = 1'b1;
          phase_nxt = PH_CODE;
        end else begin
          phase_nxt = PH_DATA;
        end
      end
      PH_DATA: begin
        if (dpos_nxt < 3'd4) begin
          vshift_nxt = {vshift_nxt[23:0], in_option_byte};
          dpos_nxt   = dpos_nxt + 3'd1;
        end
        left_nxt = left_nxt - 8'd1;
        if (left_nxt == 8'd0) begin
          commit    = 1'b1;
          phase_nxt = PH_CODE;
        end
      end
      default: ;
    endcase

    // buffer end inside an option stores what was received
    if (in_last_byte && phase_nxt != PH_IDLE) begin
      if (phase_nxt == PH_LEN) begin
        dpos_nxt   = 3'd0;
        vshift_nxt = 32'd0;
        commit     = 1'b1;
      end else if (phase_nxt == PH_DATA) begin
        commit = 1'b1;
      end
    end

    // zero-fill on the right
    unique case (dpos_nxt)
      3'd0:    commit_val = 32'd0;
      3'd1:    commit_val = {vshift_nxt[7:0], 24'd0};
      3'd2:    commit_val = {vshift_nxt[15:0], 16'd0};
      3'd3:    commit_val = {vshift_nxt[23:0], 8'd0};
      default: commit_val = vshift_nxt;
    endcase

    // store the option into every capture that matches its code
    if (commit) begin
      unique case (code_nxt)
        dhcp_lop_pkg::OPT_MASK:   store_nxt.mask   = commit_val;
        dhcp_lop_pkg::OPT_ROUTER: store_nxt.router = commit_val;
        dhcp_lop_pkg::OPT_DNS:    store_nxt.dns    = commit_val;
        dhcp_lop_pkg::OPT_SERVER: store_nxt.server = commit_val;
        dhcp_lop_pkg::OPT_LEASE:  store_nxt.lease  = commit_val;
        dhcp_lop_pkg::OPT_RENEW:  store_nxt.renew  = commit_val;
        default: ;
      endcase
      if (code_nxt == lpr_code_r) store_nxt.ctrl = commit_val;
      if (code_nxt == portset_code_r) begin
        store_nxt.port_index = commit_val[31:16];
        store_nxt.port_mask  = commit_val[15:0];
      end
    end

    // result on the last byte of an open packet
    if (in_last_byte && phase_nxt != PH_IDLE) begin
      produce      = 1'b1;
      result.lease = store_nxt;
      if (store_nxt.renew == 32'd0) result.lease.renew = {1'b0, store_nxt.lease[31:1]};
      result.cookie_valid = (phase_nxt != PH_COOKIE) && good_nxt;
      phase_nxt = PH_IDLE;
    end
  end

  // parse state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      cpos_r   <= 2'd0;
      good_r   <= 1'b1;
      code_r   <= 8'd0;
      left_r   <= 8'd0;
      dpos_r   <= 3'd0;
      vshift_r <= 32'd0;
      store_r  <= '0;
    end else if (in_acc) begin
      phase_r  <= phase_nxt;
      cpos_r   <= cpos_nxt;
      good_r   <= good_nxt;
      code_r   <= code_nxt;
      left_r   <= left_nxt;
      dpos_r   <= dpos_nxt;
      vshift_r <= vshift_nxt;
      store_r  <= store_nxt;
    end
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_acc && produce) begin
      if (!out_valid_r || out_pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_pop) begin
      out_valid_r <= 1'b0;
    end
  end

  // result payload registers
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_pop) out_data_r <= skid_data_r;
    end else if (in_acc && produce) begin
      if (!out_valid_r || out_pop) begin
        out_data_r <= result;
      end else begin
        skid_data_r <= result;
      end
    end
  end

  assign out_valid              = out_valid_r;
  assign out_client_address     = out_data_r.lease.client;
  assign out_server_address     = out_data_r.lease.server;
  assign out_subnet_mask        = out_data_r.lease.mask;
  assign out_router_address     = out_data_r.lease.router;
  assign out_dns_address        = out_data_r.lease.dns;
  assign out_controller_address = out_data_r.lease.ctrl;
  assign out_lease_seconds      = out_data_r.lease.lease;
  assign out_renew_seconds      = out_data_r.lease.renew;
  assign out_port_index         = out_data_r.lease.port_index;
  assign out_port_mask          = out_data_r.lease.port_mask;
  assign out_cookie_valid       = out_data_r.cookie_valid;

  // skid holds a result only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid full while output register empty");

  // skid fills only from an accepted last byte
  a_skid_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(in_valid && !in_stall && in_last_byte))
    else $error("skid filled without a last byte");

  // a first byte that is not also last opens the cookie phase
  a_first_opens_cookie: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_first_byte && !in_last_byte) |=> (phase_r == PH_COOKIE))
    else $error("first byte did not restart cookie check");

  // after a last byte the parser is closed
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last_byte) |=> (phase_r == PH_IDLE))
    else $error("parser still open after last byte");

endmodule

/* bench/dhcp_lease_option_parser_tb.sv */
// testbench for the dhcp lease option parser: directed table, random packets, lease predictor
`timescale 1ns / 1ps

module dhcp_lease_option_parser_tb;

  // magic cookie, first byte in the top lane
  localparam logic [31:0] COOKIE_WORD = 32'h63825363;

  typedef enum logic [5:0] {
    WALK_IDLE   = 6'b000001,
    WALK_COOKIE = 6'b000010,
    WALK_CODE   = 6'b000100,
    WALK_LEN    = 6'b001000,
    WALK_DATA   = 6'b010000,
    WALK_END    = 6'b100000
  } walk_phase_t;

  // one directed stimulus row, with an optional hand-written lease
  typedef struct {
    logic [7:0]            b;
    logic                  first;
    logic                  last;
    logic [31:0]           addr;
    bit                    has_lease;
    dhcp_lop_pkg::result_t lease;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_option_byte = '0;
  logic        in_first_byte = 1'b0;
  logic        in_last_byte = 1'b0;
  logic [31:0] in_offered_address = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_client_address;
  logic [31:0] out_server_address;
  logic [31:0] out_subnet_mask;
  logic [31:0] out_router_address;
  logic [31:0] out_dns_address;
  logic [31:0] out_controller_address;
  logic [31:0] out_lease_seconds;
  logic [31:0] out_renew_seconds;
  logic [15:0] out_port_index;
  logic [15:0] out_port_mask;
  logic        out_cookie_valid;
  logic                                 cfg_write_en = 1'b0;
  logic [dhcp_lop_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0]                           cfg_wdata = '0;

  // lease predictor state
  walk_phase_t          walk;
  logic [1:0]           ck_pos;
  logic                 ck_ok;
  logic [7:0]           opt_code;
  logic [7:0]           opt_left;
  logic [7:0]           opt_got;
  logic [31:0]          opt_value;
  dhcp_lop_pkg::store_t captured;
  logic [7:0]           portset_code;
  logic [7:0]           lpr_code;

  dhcp_lop_pkg::result_t pending_leases[$];
  stim_row_t             lease_rows[$];
  int                    fail_count = 0;
  int                    tx_idle_pct = 0;
  int                    rx_stall_pct = 0;
  int                    bytes_sent = 0;
  int                    leases_due = 0;

  dhcp_lease_option_parser dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_option_byte         (in_option_byte),
    .in_first_byte          (in_first_byte),
    .in_last_byte           (in_last_byte),
    .in_offered_address     (in_offered_address),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_client_address     (out_client_address),
    .out_server_address     (out_server_address),
    .out_subnet_mask        (out_subnet_mask),
    .out_router_address     (out_router_address),
    .out_dns_address        (out_dns_address),
    .out_controller_address (out_controller_address),
    .out_lease_seconds      (out_lease_seconds),
    .out_renew_seconds      (out_renew_seconds),
    .out_port_index         (out_port_index),
    .out_port_mask          (out_port_mask),
    .out_cookie_valid       (out_cookie_valid),
    .cfg_write_en           (cfg_write_en),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_stall <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);
  end

  // store an option value into every capture whose code matches
  function automatic void store_option();
    logic [31:0] v;
    v = opt_value << (8 * (4 - int'(opt_got)));
    case (opt_code)
      dhcp_lop_pkg::OPT_MASK:   captured.mask = v;
      dhcp_lop_pkg::OPT_ROUTER: captured.router = v;
      dhcp_lop_pkg::OPT_DNS:    captured.dns = v;
      dhcp_lop_pkg::OPT_SERVER: captured.server = v;
      dhcp_lop_pkg::OPT_LEASE:  captured.lease = v;
      dhcp_lop_pkg::OPT_RENEW:  captured.renew = v;
      default: ;
    endcase
    if (opt_code == lpr_code) captured.ctrl = v;
    if (opt_code == portset_code) begin
      captured.port_index = v[31:16];
      captured.port_mask = v[15:0];
    end
  endfunction

  // advance the option walk by one byte; returns 1 when a lease is due
  function automatic bit parse_byte(input logic [7:0] b, input logic first, input logic last,
                                    input logic [31:0] addr,
                                    output dhcp_lop_pkg::result_t lease);
    lease = '0;
    if (first) begin
      ck_pos = '0;
      ck_ok = 1'b1;
      opt_code = '0;
      opt_left = '0;
      opt_got = '0;
      opt_value = '0;
      captured = '0;
      captured.client = addr;
      walk = WALK_COOKIE;
    end
    case (walk)
      WALK_COOKIE: begin
        if (b != COOKIE_WORD[31 - 8 * ck_pos -: 8]) ck_ok = 1'b0;
        if (ck_pos == 2'd3) walk = WALK_CODE;
        ck_pos = ck_pos + 2'd1;
      end
      WALK_CODE: begin
        if (b == dhcp_lop_pkg::OPT_END) walk = WALK_END;
        else if (b != dhcp_lop_pkg::OPT_PAD) begin
          opt_code = b;
          walk = WALK_LEN;
        end
      end
      WALK_LEN: begin
        opt_left = b;
        opt_got = '0;
        opt_value = '0;
        if (b == 8'd0) begin
          store_option();
          walk = WALK_CODE;
        end else begin
          walk = WALK_DATA;
        end
      end
      WALK_DATA: begin
        if (opt_got < 8'd4) begin
          opt_value = {opt_value[23:0], b};
          opt_got = opt_got + 8'd1;
        end
        opt_left = opt_left - 8'd1;
        if (opt_left == 8'd0) begin
          store_option();
          walk = WALK_CODE;
        end
      end
      default: ;
    endcase
    if (!last || walk == WALK_IDLE) return 1'b0;
    // buffer ended inside an option: keep what arrived
    if (walk == WALK_LEN) begin
      opt_got = '0;
      opt_value = '0;
      store_option();
    end else if (walk == WALK_DATA) begin
      store_option();
    end
    lease.lease = captured;
    if (captured.renew == 32'd0) lease.lease.renew = captured.lease >> 1;
    lease.cookie_valid = (walk != WALK_COOKIE) && ck_ok;
    walk = WALK_IDLE;
    return 1'b1;
  endfunction

  function automatic stim_row_t row(input logic [7:0] b, input logic first, input logic last,
                                    input logic [31:0] addr, input bit has_lease = 1'b0,
                                    input dhcp_lop_pkg::result_t lease = '0);
    stim_row_t r;
    r.b = b;
    r.first = first;
    r.last = last;
    r.addr = addr;
    r.has_lease = has_lease;
    r.lease = lease;
    return r;
  endfunction

  function automatic dhcp_lop_pkg::result_t lease_of(
      input logic [31:0] client, input logic [31:0] server, input logic [31:0] mask,
      input logic [31:0] lease_s, input logic [31:0] renew_s, input logic cookie);
    dhcp_lop_pkg::result_t r;
    r = '0;
    r.lease.client = client;
    r.lease.server = server;
    r.lease.mask = mask;
    r.lease.lease = lease_s;
    r.lease.renew = renew_s;
    r.cookie_valid = cookie;
    return r;
  endfunction

  function automatic logic [7:0] data_byte();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hff;
    return 8'($urandom);
  endfunction

  // drive one byte transaction; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic first, input logic last,
                           input logic [31:0] addr, input bit has_lease = 1'b0,
                           input dhcp_lop_pkg::result_t typed = '0);
    dhcp_lop_pkg::result_t lease;
    bit                    due;
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      in_option_byte = 8'($urandom);
      in_first_byte = 1'($urandom);
      in_last_byte = 1'($urandom);
      in_offered_address = $urandom;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_option_byte = b;
    in_first_byte = first;
    in_last_byte = last;
    in_offered_address = addr;
    do @(posedge clk); while (in_stall);
    due = parse_byte(b, first, last, addr, lease);
    if (has_lease) pending_leases.push_back(typed);
    else if (due) pending_leases.push_back(lease);
    @(negedge clk);
  endtask

  // quiet the input and wait for every lease to come out
  task automatic drain();
    in_valid = 1'b0;
    while (pending_leases.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [dhcp_lop_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [7:0] val);
    cfg_write_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_write_en = 1'b0;
    if (idx == dhcp_lop_pkg::CFG_PORTSET_CODE) portset_code = val;
    else lpr_code = val;
  endtask

  // build the options area of one packet: cookie, options, usually an end code
  task automatic build_packet(ref logic [7:0] pkt[$]);
    int n_opt;
    int len;
    int r;
    logic [7:0] code;
    pkt.delete();
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(99) < 6) pkt.push_back(8'($urandom));
      else pkt.push_back(COOKIE_WORD[31 - 8 * i -: 8]);
    end
    n_opt = $urandom_range(0, 5);
    for (int k = 0; k < n_opt; k++) begin
      if ($urandom_range(99) < 8) begin
        pkt.push_back(dhcp_lop_pkg::OPT_PAD);
        continue;
      end
      case ($urandom_range(0, 9))
        0: code = dhcp_lop_pkg::OPT_MASK;
        1: code = dhcp_lop_pkg::OPT_ROUTER;
        2: code = dhcp_lop_pkg::OPT_DNS;
        3: code = dhcp_lop_pkg::OPT_SERVER;
        4: code = dhcp_lop_pkg::OPT_LEASE;
        5: code = dhcp_lop_pkg::OPT_RENEW;
        6: code = portset_code;
        7: code = lpr_code;
        default: code = 8'($urandom);
      endcase
      r = $urandom_range(99);
      if (r < 65) len = 4;
      else if (r < 98) len = $urandom_range(0, 8);
      else len = $urandom_range(9, 255);
      pkt.push_back(code);
      pkt.push_back(8'(len));
      for (int j = 0; j < len; j++) pkt.push_back(data_byte());
    end
    if ($urandom_range(99) < 85) begin
      pkt.push_back(dhcp_lop_pkg::OPT_END);
      repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom));
    end
  endtask

  task automatic play_packet(ref logic [7:0] pkt[$], input bit close);
    logic [31:0] addr;
    case ($urandom_range(0, 9))
      0: addr = 32'h0;
      1: addr = 32'hffffffff;
      default: addr = $urandom;
    endcase
    for (int i = 0; i < pkt.size(); i++) begin
      send_byte(pkt[i], i == 0, close && i == pkt.size() - 1, (i == 0) ? addr : $urandom);
      bytes_sent++;
    end
    if (close) leases_due++;
  endtask

  // one random packet, sometimes cut short or restarted by a new first byte
  task automatic random_packet();
    logic [7:0] pkt[$];
    int kind;
    build_packet(pkt);
    kind = $urandom_range(99);
    if (kind < 8) begin
      pkt = pkt[0:$urandom_range(0, pkt.size() - 1)];
      play_packet(pkt, 1'b0);
      build_packet(pkt);
    end else if (kind < 20) begin
      pkt = pkt[0:$urandom_range(0, pkt.size() - 1)];
    end
    play_packet(pkt, 1'b1);
  endtask

  // result checker
  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    dhcp_lop_pkg::result_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_leases.size() == 0) begin
        $error("result transaction with nothing pending");
        fail_count++;
      end else begin
        w = pending_leases.pop_front();
        check_field("client_address", w.lease.client, out_client_address);
        check_field("server_address", w.lease.server, out_server_address);
        check_field("subnet_mask", w.lease.mask, out_subnet_mask);
        check_field("router_address", w.lease.router, out_router_address);
        check_field("dns_address", w.lease.dns, out_dns_address);
        check_field("controller_address", w.lease.ctrl, out_controller_address);
        check_field("lease_seconds", w.lease.lease, out_lease_seconds);
        check_field("renew_seconds", w.lease.renew, out_renew_seconds);
        check_field("port_index", 32'(w.lease.port_index), 32'(out_port_index));
        check_field("port_mask", 32'(w.lease.port_mask), 32'(out_port_mask));
        check_field("cookie_valid", 32'(w.cookie_valid), 32'(out_cookie_valid));
      end
    end
  end

  // stimulus
  initial begin
    int seg_bytes;
    int pkt_n;
    walk = WALK_IDLE;
    captured = '0;
    ck_pos = '0;
    ck_ok = 1'b1;
    opt_code = '0;
    opt_left = '0;
    opt_got = '0;
    opt_value = '0;
    portset_code = dhcp_lop_pkg::PORTSET_CODE_RST;
    lpr_code = dhcp_lop_pkg::LPR_CODE_RST;

    // directed table, reset register values
    lease_rows.push_back(row(8'hff, 1'b0, 1'b1, 32'h0));            // ignored while idle
    lease_rows.push_back(row(8'h63, 1'b1, 1'b0, 32'h0bad0bad));     // restarted below
    lease_rows.push_back(row(8'h63, 1'b1, 1'b0, 32'hffffffff));
    lease_rows.push_back(row(8'h82, 1'b0, 1'b0, 32'h0));
    lease_rows.push_back(row(8'h53, 1'b0, 1'b0, 32'h0));
    lease_rows.push_back(row(8'h63, 1'b0, 1'b0, 32'h0));
    lease_rows.push_back(row(dhcp_lop_pkg::OPT_PAD, 1'b0, 1'b0, 32'h0));
    // two data bytes only
    lease_rows.push_back(row(dhcp_lop_pkg::OPT_MASK, 1'b0, 1'b0, 32'h0));
    lease_rows.push_back(row(8'h02, 1'b0, 1'b0, 32'h0));
    lease_rows.push_back(row(8'hc0, 1'b0, 1'b0, 32'h0));
    lease_rows.push_back(row(8'ha8, 1'b0, 1'b0, 32'h0));
    // five data bytes
    lease_rows.push_back(row(dhcp_lop_pkg::OPT_SERVER, 1'b0, 1'b0, 32'h0));
    lease_rows.push_back(row(8'h05, 1'b0, 1'b0, 32'h0));
    lease_rows.push_back(row(8'h0a, 1'b0, 1'b0, 32'h0));
    lease_rows.push_back(row(8'h00, 1'b0, 1'b0, 32'h0));
    lease_rows.push_back(row(8'h00, 1'b0, 1'b0, 32'h0));
    lease_rows.push_back(row(8'h01, 1'b0, 1'b0, 32'h0));
    lease_rows.push_back(row(8'hff, 1'b0, 1'b0, 32'h0));
    lease_rows.push_back(row(dhcp_lop_pkg::OPT_END, 1'b0, 1'b0, 32'h0));
    lease_rows.push_back(row(8'h12, 1'b0, 1'b1, 32'h0, 1'b1,
        lease_of(32'hffffffff, 32'h0a000001, 32'hc0a80000, 32'h0, 32'h0, 1'b1)));
    // buffer ends inside the cookie
    lease_rows.push_back(row(8'h63, 1'b1, 1'b1, 32'h0, 1'b1,
        lease_of(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0)));
    // bad cookie, buffer ends inside the lease option
    lease_rows.push_back(row(8'h00, 1'b1, 1'b0, 32'h5a5aa5a5));
    lease_rows.push_back(row(8'h82, 1'b0, 1'b0, 32'h0));
    lease_rows.push_back(row(8'h53, 1'b0, 1'b0, 32'h0));
    lease_rows.push_back(row(8'h63, 1'b0, 1'b0, 32'h0));
    lease_rows.push_back(row(dhcp_lop_pkg::OPT_LEASE, 1'b0, 1'b0, 32'h0));
    lease_rows.push_back(row(8'h02, 1'b0, 1'b0, 32'h0));
    lease_rows.push_back(row(8'hfe, 1'b0, 1'b1, 32'h0, 1'b1,
        lease_of(32'h5a5aa5a5, 32'h0, 32'h0, 32'hfe000000, 32'h7f000000, 1'b0)));

    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    tx_idle_pct = 12;
    rx_stall_pct = 51;
    foreach (lease_rows[i]) begin
      send_byte(lease_rows[i].b, lease_rows[i].first, lease_rows[i].last, lease_rows[i].addr,
                lease_rows[i].has_lease, lease_rows[i].lease);
    end

    // random packets in six segments, each with its own register setting
    for (int seg = 0; seg < 6; seg++) begin
      tx_idle_pct = (seg < 2) ? 12 : (seg < 4) ? 51 : 0;
      rx_stall_pct = (seg < 2) ? 51 : (seg < 4) ? 12 : 0;
      drain();
      repeat (4) @(negedge clk);
      case (seg)
        0: begin
          cfg_write(dhcp_lop_pkg::CFG_PORTSET_CODE, 8'd0);
          cfg_write(dhcp_lop_pkg::CFG_LPR_CODE, 8'd255);
        end
        1: begin
          cfg_write(dhcp_lop_pkg::CFG_PORTSET_CODE, 8'd255);
          cfg_write(dhcp_lop_pkg::CFG_LPR_CODE, 8'd0);
        end
        2: begin
          cfg_write(dhcp_lop_pkg::CFG_PORTSET_CODE, dhcp_lop_pkg::OPT_LEASE);
          cfg_write(dhcp_lop_pkg::CFG_LPR_CODE, dhcp_lop_pkg::OPT_LEASE);
        end
        3: begin
          cfg_write(dhcp_lop_pkg::CFG_PORTSET_CODE, dhcp_lop_pkg::OPT_ROUTER);
          cfg_write(dhcp_lop_pkg::CFG_LPR_CODE, 8'd200);
        end
        4: begin
          cfg_write(dhcp_lop_pkg::CFG_PORTSET_CODE, 8'($urandom));
          cfg_write(dhcp_lop_pkg::CFG_LPR_CODE, 8'($urandom));
        end
        default: begin
          cfg_write(dhcp_lop_pkg::CFG_PORTSET_CODE, dhcp_lop_pkg::PORTSET_CODE_RST);
          cfg_write(dhcp_lop_pkg::CFG_LPR_CODE, dhcp_lop_pkg::LPR_CODE_RST);
        end
      endcase
      seg_bytes = bytes_sent;
      pkt_n = 0;
      while (bytes_sent - seg_bytes < 85) begin
        // stray bytes while no packet is open
        if ($urandom_range(99) < 10) begin
          repeat ($urandom_range(1, 3))
            send_byte(8'($urandom), 1'b0, 1'($urandom), $urandom);
        end
        // hold off until every lease has come out
        if (pkt_n == 1 || $urandom_range(99) < 3) drain();
        random_packet();
        pkt_n++;
      end
    end

    in_valid = 1'b0;
    while (pending_leases.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/dhcp_lop_pkg.sv
rtl/core/dhcp_lease_option_parser.sv
bench/dhcp_lease_option_parser_tb.sv
